>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl of the json string escaper
// no dependencies; taken in by `include where a module checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed in %m");

// condition must never be seen at a clock edge out of reset
`define CHK_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen in %m");

`endif

>>> rtl/core/jse_pkg.sv
// types, constants and helper functions for the json string escaper
// no dependencies; used by every module in rtl/core
package jse_pkg;

    // descriptor queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // most characters one transaction can cause
    localparam int MAX_CHARS = 8;
    localparam int CIDX_W    = $clog2(MAX_CHARS);
    localparam int CCNT_W    = $clog2(MAX_CHARS + 1);

    localparam logic [7:0] SURR_LEAD  = 8'hED;
    localparam logic [7:0] SURR_MIN   = 8'hA0;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_U       = 8'h75;

    // body kinds
    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_PLAIN = 2'd1;
    localparam logic [1:0] K_ESC   = 2'd2;
    localparam logic [1:0] K_UNI   = 2'd3;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       first_byte;
        logic       last_byte;
        logic       empty_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_out;
        logic       run_last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] val;
    } t_body;

    // one transaction's output, in classified form
    typedef struct packed {
        logic        open_q;
        logic        pre_en;
        logic [7:0]  pre_byte;
        logic [1:0]  kind;
        logic [15:0] val;
        logic        close_q;
    } t_desc;

    typedef logic [MAX_CHARS-1:0][7:0] t_chars;

    typedef struct packed {
        t_chars             chars;
        logic [CCNT_W-1:0]  cnt;
    } t_exp;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = 8'h30 + {4'd0, n};
        end else begin
            c = 8'h57 + {4'd0, n};
        end
        return c;
    endfunction

    function automatic t_body classify(input logic [7:0] b);
        t_body r;
        r.kind = K_ESC;
        r.val  = '0;
        unique case (b)
            8'h22:   r.val[7:0] = CH_QUOTE;
            8'h5C:   r.val[7:0] = CH_BSLASH;
            8'h08:   r.val[7:0] = 8'h62;
            8'h0C:   r.val[7:0] = 8'h66;
            8'h0A:   r.val[7:0] = 8'h6E;
            8'h0D:   r.val[7:0] = 8'h72;
            8'h09:   r.val[7:0] = 8'h74;
            default: begin
                if (b < CTRL_LIMIT) begin
                    r.kind = K_UNI;
                end else begin
                    r.kind = K_PLAIN;
                end
                r.val = {8'h00, b};
            end
        endcase
        return r;
    endfunction

    function automatic t_exp expand(input t_desc d);
        t_exp              e;
        logic [5:0][7:0]   body;
        logic [2:0]        blen;
        logic [CCNT_W-1:0] p;
        e    = '0;
        body = '0;
        blen = '0;
        p    = '0;
        unique case (d.kind)
            K_PLAIN: begin
                body[0] = d.val[7:0];
                blen    = 3'd1;
            end
            K_ESC: begin
                body[0] = CH_BSLASH;
                body[1] = d.val[7:0];
                blen    = 3'd2;
            end
            K_UNI: begin
                body[0] = CH_BSLASH;
                body[1] = CH_U;
                body[2] = hex_char(d.val[15:12]);
                body[3] = hex_char(d.val[11:8]);
                body[4] = hex_char(d.val[7:4]);
                body[5] = hex_char(d.val[3:0]);
                blen    = 3'd6;
            end
            default: blen = 3'd0;
        endcase
        if (d.open_q) begin
            e.chars[p[CIDX_W-1:0]] = CH_QUOTE;
            p = p + CCNT_W'(1);
        end
        if (d.pre_en) begin
            e.chars[p[CIDX_W-1:0]] = d.pre_byte;
            p = p + CCNT_W'(1);
        end
        for (int i = 0; i < 6; i++) begin
            if (3'(i) < blen) begin
                e.chars[p[CIDX_W-1:0]] = body[i];
                p = p + CCNT_W'(1);
            end
        end
        if (d.close_q) begin
            e.chars[p[CIDX_W-1:0]] = CH_QUOTE;
            p = p + CCNT_W'(1);
        end
        e.cnt = p;
        return e;
    endfunction

endpackage

>>> rtl/core/jse_front.sv
// front end: accepts input transactions, tracks held surrogate bytes, classifies
// depends on jse_pkg and assert_macros.svh
`include "assert_macros.svh"

module jse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  jse_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              o_full,
    output logic              o_enq,
    output jse_pkg::t_desc    o_desc
);

    logic [1:0] r_held_count, n_held_count;
    logic [7:0] r_held0, n_held0;
    logic [7:0] r_held1, n_held1;
    logic       accept;
    logic       fresh;
    logic [1:0] hc;
    logic [7:0] b;
    jse_pkg::t_body bd;
    jse_pkg::t_desc d;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;
    assign b      = i_item.byte_in;
    assign bd     = jse_pkg::classify(i_item.byte_in);

    always_comb begin
        n_held_count = r_held_count;
        n_held0      = r_held0;
        n_held1      = r_held1;
        d            = '0;
        fresh        = 1'b0;
        hc           = r_held_count;
        if (i_item.empty_string) begin
            n_held_count = 2'd0;
            d.open_q     = 1'b1;
            d.close_q    = 1'b1;
        end else begin
            d.open_q = i_item.first_byte;
            // a new string drops whatever the unfinished one held back
            if (i_item.first_byte) begin
                hc = 2'd0;
            end
            if (hc == 2'd2) begin
                d.kind       = jse_pkg::K_UNI;
                d.val        = {r_held0[3:0], r_held1[5:0], b[5:0]};
                n_held_count = 2'd0;
            end else if (hc == 2'd1) begin
                if (b >= jse_pkg::SURR_MIN && !i_item.last_byte) begin
                    n_held1      = b;
                    n_held_count = 2'd2;
                end else begin
                    d.pre_en     = 1'b1;
                    d.pre_byte   = r_held0;
                    n_held_count = 2'd0;
                    fresh        = 1'b1;
                end
            end else begin
                n_held_count = 2'd0;
                fresh        = 1'b1;
            end
            if (fresh) begin
                if (b == jse_pkg::SURR_LEAD && !i_item.last_byte) begin
                    n_held0      = b;
                    n_held_count = 2'd1;
                end else begin
                    d.kind = bd.kind;
                    d.val  = bd.val;
                end
            end
            d.close_q = i_item.last_byte;
        end
    end

    assign o_desc = d;
    assign o_enq  = accept && (d.open_q || d.pre_en || d.close_q
                               || (d.kind != jse_pkg::K_NONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= 2'd0;
        end else if (accept) begin
            r_held_count <= n_held_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held0 <= n_held0;
            r_held1 <= n_held1;
        end
    end

    `CHK_NEVER(a_held_range, i_clk, i_rst_n, r_held_count == 2'd3)
    `CHK_ASSERT(a_empty_clears, i_clk, i_rst_n, (accept && i_item.empty_string) |=> (r_held_count == 2'd0))
    `CHK_ASSERT(a_silent_holds, i_clk, i_rst_n, (accept && !o_enq) |=> (r_held_count != 2'd0))

endmodule

>>> rtl/core/jse_queue.sv
// short descriptor queue between the front and back ends
// depends on jse_pkg and assert_macros.svh
`include "assert_macros.svh"

module jse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_enq,
    input  jse_pkg::t_desc i_desc,
    input  logic           i_deq,
    output logic           o_full,
    output logic           o_empty,
    output jse_pkg::t_desc o_head
);

    jse_pkg::t_desc r_mem [jse_pkg::QDEPTH];
    logic [jse_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [jse_pkg::QCNT_W-1:0] r_count;
    logic do_enq, do_deq;

    assign o_full  = (r_count == jse_pkg::QCNT_W'(jse_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign do_enq  = i_enq && !o_full;
    assign do_deq  = i_deq && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_enq) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_enq) begin
                r_wr <= r_wr + jse_pkg::QPTR_W'(1);
            end
            if (do_deq) begin
                r_rd <= r_rd + jse_pkg::QPTR_W'(1);
            end
            if (do_enq && !do_deq) begin
                r_count <= r_count + jse_pkg::QCNT_W'(1);
            end else if (do_deq && !do_enq) begin
                r_count <= r_count - jse_pkg::QCNT_W'(1);
            end
        end
    end

    `CHK_NEVER(a_q_over, i_clk, i_rst_n, r_count > jse_pkg::QCNT_W'(jse_pkg::QDEPTH))
    `CHK_ASSERT(a_q_grow, i_clk, i_rst_n, (do_enq && !do_deq) |=> (r_count == $past(r_count) + jse_pkg::QCNT_W'(1)))

endmodule

>>> rtl/core/jse_back.sv
// back end: expands the head descriptor and hands out one character per pop
// depends on jse_pkg and assert_macros.svh
`include "assert_macros.svh"

module jse_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jse_pkg::t_desc     i_head,
    input  logic               i_q_empty,
    input  logic               i_pop,
    output logic               o_deq,
    output logic               o_empty,
    output jse_pkg::t_out_item o_item
);

    logic [jse_pkg::CIDX_W-1:0] r_idx;
    jse_pkg::t_exp exp_h;
    logic          is_last;
    logic          take;

    assign exp_h   = jse_pkg::expand(i_head);
    assign is_last = ({1'b0, r_idx} == (exp_h.cnt - jse_pkg::CCNT_W'(1)));
    assign o_empty = i_q_empty;
    assign take    = i_pop && !i_q_empty;
    assign o_deq   = take && is_last;

    assign o_item.char_out = exp_h.chars[r_idx];
    assign o_item.run_last = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (take) begin
            if (is_last) begin
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + jse_pkg::CIDX_W'(1);
            end
        end
    end

    // a descriptor stays at the head until its last character goes
    `CHK_ASSERT(a_run_continues, i_clk, i_rst_n, (take && !is_last) |=> (!o_empty && (r_idx == $past(r_idx) + jse_pkg::CIDX_W'(1))))

endmodule

>>> rtl/core/json_string_escape.sv
// top level of the json string escaper: front end, descriptor queue, back end
// depends on jse_pkg, jse_front, jse_queue and jse_back
//
// channel   handshake            payload
// input     push / full          i_item (jse_pkg::t_in_item)
// result    empty / pop          o_item (jse_pkg::t_out_item)
//
// the front end takes one transaction per cycle while the four-entry queue has room
// the back end gives one character per cycle while pop is high, so a transaction costs 1 to 8 characters
// of the result channel; a held surrogate byte gives no character at all
// with the queue empty, the first character of an accepted transaction reaches the result ports in the next cycle
// synchronous active-low reset empties the queue and drops held bytes
module json_string_escape (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  jse_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output jse_pkg::t_out_item o_item
);

    logic           enq, deq, q_full, q_empty;
    jse_pkg::t_desc desc, head;

    jse_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_full   (full),
        .o_enq    (enq),
        .o_desc   (desc)
    );

    jse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (enq),
        .i_desc  (desc),
        .i_deq   (deq),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    jse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_q_empty (q_empty),
        .i_pop     (pop),
        .o_deq     (deq),
        .o_empty   (empty),
        .o_item    (o_item)
    );

endmodule

>>> bench/tb_json_string_escape.sv
// self-checking bench for json_string_escape: directed and random byte streams
// depends on jse_pkg and the json_string_escape rtl; predicts every quoted character
`timescale 1ns / 1ps

module tb_json_string_escape;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 16;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    jse_pkg::t_in_item  i_item = '0;
    logic               empty;
    logic               pop = 1'b0;
    jse_pkg::t_out_item o_item;

    // predictor state: bytes of a possible lone surrogate held back
    logic [7:0] held_lead = '0;
    logic [7:0] held_mid = '0;
    logic [1:0] held_cnt = '0;

    jse_pkg::t_out_item exp_chars[$];
    logic [7:0]         step_chars[$];

    int errors = 0;
    int cycle_count = 0;
    int send_gap_max = 0;
    int pop_gap_max = 0;
    int sent_count = 0;

    json_string_escape dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] to_hex(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h61 + 8'(n) - 8'd10);
    endfunction

    function automatic void put_char(input logic [7:0] c);
        if (step_chars.size() < jse_pkg::MAX_CHARS) begin
            step_chars = {step_chars, c};
        end
    endfunction

    function automatic void put_plain(input logic [7:0] b);
        case (b)
            jse_pkg::CH_QUOTE: begin
                put_char(jse_pkg::CH_BSLASH);
                put_char(jse_pkg::CH_QUOTE);
            end
            jse_pkg::CH_BSLASH: begin
                put_char(jse_pkg::CH_BSLASH);
                put_char(jse_pkg::CH_BSLASH);
            end
            8'h08:     begin put_char(jse_pkg::CH_BSLASH); put_char("b"); end
            8'h0C:     begin put_char(jse_pkg::CH_BSLASH); put_char("f"); end
            8'h0A:     begin put_char(jse_pkg::CH_BSLASH); put_char("n"); end
            8'h0D:     begin put_char(jse_pkg::CH_BSLASH); put_char("r"); end
            8'h09:     begin put_char(jse_pkg::CH_BSLASH); put_char("t"); end
            default: begin
                if (b < jse_pkg::CTRL_LIMIT) begin
                    put_char(jse_pkg::CH_BSLASH);
                    put_char(jse_pkg::CH_U);
                    put_char("0");
                    put_char("0");
                    put_char(to_hex(b[7:4]));
                    put_char(to_hex(b[3:0]));
                end else begin
                    put_char(b);
                end
            end
        endcase
    endfunction

    function automatic void start_byte(input logic [7:0] b, input logic last);
        if (b == jse_pkg::SURR_LEAD && !last) begin
            held_lead = b;
            held_cnt  = 2'd1;
        end else begin
            put_plain(b);
        end
    endfunction

    // works out the characters one accepted transaction causes
    function automatic void predict_escape(input jse_pkg::t_in_item it);
        logic [15:0]        cp;
        jse_pkg::t_out_item oc;
        step_chars.delete();
        if (it.empty_string) begin
            held_cnt = 2'd0;
            put_char(jse_pkg::CH_QUOTE);
            put_char(jse_pkg::CH_QUOTE);
        end else begin
            if (it.first_byte) begin
                held_cnt = 2'd0;
                put_char(jse_pkg::CH_QUOTE);
            end
            if (held_cnt >= 2'd2) begin
                cp = {held_lead[3:0], held_mid[5:0], it.byte_in[5:0]};
                put_char(jse_pkg::CH_BSLASH);
                put_char(jse_pkg::CH_U);
                put_char(to_hex(cp[15:12]));
                put_char(to_hex(cp[11:8]));
                put_char(to_hex(cp[7:4]));
                put_char(to_hex(cp[3:0]));
                held_cnt = 2'd0;
            end else if (held_cnt == 2'd1) begin
                if (it.byte_in >= jse_pkg::SURR_MIN && !it.last_byte) begin
                    held_mid = it.byte_in;
                    held_cnt = 2'd2;
                end else begin
                    put_char(held_lead);
                    held_cnt = 2'd0;
                    start_byte(it.byte_in, it.last_byte);
                end
            end else begin
                start_byte(it.byte_in, it.last_byte);
            end
            if (it.last_byte) begin
                put_char(jse_pkg::CH_QUOTE);
            end
        end
        foreach (step_chars[i]) begin
            oc.char_out = step_chars[i];
            oc.run_last = (i == step_chars.size() - 1);
            exp_chars   = {exp_chars, oc};
        end
    endfunction

    // one input transaction, after a random gap; push stays high when no gap
    task automatic send_text_byte(input logic [7:0] b, input logic first,
                                  input logic last, input logic empty_str);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= '{byte_in: b, first_byte: first, last_byte: last,
                    empty_string: empty_str};
        do @(posedge i_clk); while (full);
        predict_escape('{byte_in: b, first_byte: first, last_byte: last,
                         empty_string: empty_str});
        sent_count++;
    endtask

    task automatic send_string(input logic [7:0] text[$]);
        foreach (text[i]) begin
            send_text_byte(text[i], i == 0, i == text.size() - 1, 1'b0);
        end
    endtask

    // result side: random stalls, each result character checked against the oldest expectation
    initial begin : result_checker
        int stall;
        jse_pkg::t_out_item want;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, pop_gap_max);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (exp_chars.size() == 0) begin
                $display("%0t: unexpected result char_out=%h run_last=%b",
                         $realtime, o_item.char_out, o_item.run_last);
                errors++;
            end else begin
                want = exp_chars.pop_front();
                if (o_item.char_out !== want.char_out) begin
                    $display("%0t: char_out mismatch expected %h actual %h",
                             $realtime, want.char_out, o_item.char_out);
                    errors++;
                end
                if (o_item.run_last !== want.run_last) begin
                    $display("%0t: run_last mismatch expected %b actual %b",
                             $realtime, want.run_last, o_item.run_last);
                    errors++;
                end
            end
        end
    end

    task automatic test_plain_escapes();
        send_gap_max = 4;
        pop_gap_max  = 4;
        send_text_byte(8'hFF, 1'b1, 1'b1, 1'b1);
        send_string('{8'h61});
        send_string('{8'h00, 8'hFF, jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH,
                      8'h08, 8'h0C, 8'h0A});
        send_string('{8'h0D, 8'h09, 8'h1F, 8'h7F, 8'h80, 8'h20});
    endtask

    task automatic test_lone_surrogates();
        send_gap_max = 2;
        pop_gap_max  = 8;
        // complete escape, including the top byte values
        send_string('{jse_pkg::SURR_LEAD, 8'hBF, 8'hFF});
        // second byte too small, and a lead that is itself last
        send_string('{jse_pkg::SURR_LEAD, 8'h9F, jse_pkg::SURR_LEAD});
        // second byte marked last, so nothing can complete it
        send_string('{jse_pkg::SURR_LEAD, jse_pkg::SURR_MIN});
    endtask

    task automatic test_broken_strings();
        send_gap_max = 0;
        pop_gap_max  = 16;
        // held bytes dropped by a new first byte, then by an empty string
        send_text_byte(jse_pkg::SURR_LEAD, 1'b1, 1'b0, 1'b0);
        send_text_byte(8'hA5, 1'b0, 1'b0, 1'b0);
        send_text_byte(8'h41, 1'b1, 1'b0, 1'b0);
        send_text_byte(jse_pkg::SURR_LEAD, 1'b0, 1'b0, 1'b0);
        send_text_byte(8'h00, 1'b1, 1'b1, 1'b1);
        // no first mark; held lead flushed ahead of a control escape
        send_text_byte(jse_pkg::SURR_LEAD, 1'b0, 1'b0, 1'b0);
        send_text_byte(8'h01, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_random_traffic(input int n_items, input int in_max, input int out_max);
        logic [7:0] text[$];
        logic [7:0] nb;
        int len;
        int target;
        send_gap_max = in_max;
        pop_gap_max  = out_max;
        target = sent_count + n_items;
        while (sent_count < target) begin
            if ($urandom_range(0, 99) < 12) begin
                send_text_byte(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                len = $urandom_range(0, 8);
                text.delete();
                while (text.size() < len) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: begin
                            nb   = 8'($urandom_range(8'h20, 8'h7E));
                            text = {text, nb};
                        end
                        4: begin
                            nb   = 8'($urandom_range(0, 8'h1F));
                            text = {text, nb};
                        end
                        5: begin
                            nb   = $urandom_range(0, 1) ? jse_pkg::CH_QUOTE
                                                        : jse_pkg::CH_BSLASH;
                            text = {text, nb};
                        end
                        6: begin
                            nb   = 8'($urandom_range(8'h80, 8'hFF));
                            text = {text, nb};
                        end
                        default: begin
                            nb   = $urandom_range(0, 3) ? 8'($urandom_range(8'hA0, 8'hFF))
                                                        : 8'($urandom);
                            text = {text, jse_pkg::SURR_LEAD, nb};
                            nb   = 8'($urandom);
                            text = {text, nb};
                        end
                    endcase
                end
                while (text.size() > len) text.delete(text.size() - 1);
                if (len == 0) begin
                    send_text_byte(8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
                end else begin
                    send_string(text);
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_escapes();
        test_lone_surrogates();
        test_broken_strings();
        test_random_traffic(80, 16, 16);
        test_random_traffic(65, 0, 0);
        test_random_traffic(60, 0, 16);
        test_random_traffic(60, 16, 0);
        push <= 1'b0;
        while (exp_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
